[src/percent_uri_codec_core_macros.svh]
// Assertion macros of the percent URI codec RTL.
`ifndef PERCENT_URI_CODEC_CORE_MACROS_SVH
`define PERCENT_URI_CODEC_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of i_clk while the block is out of reset.
`define PCODEC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pcodec assertion failed");
// Checked on every rising edge of i_clk, reset included.
`define PCODEC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("pcodec assertion failed");
`else
`define PCODEC_ASSERT(lbl, prop)
`define PCODEC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[src/pcodec_pkg.sv]
// Types, constants and byte classification functions of the percent URI codec.
package pcodec_pkg;

    localparam int unsigned Q_DEPTH    = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_HI = 2'd2;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] CH_PCT = 8'h25;

    typedef struct packed {
        logic        mode;
        logic [63:0] extra_lo;
        logic [63:0] extra_hi;
    } t_cfg;

    // Up to three output bytes produced by one input byte.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic is_literal(logic [7:0] b, logic [63:0] lo, logic [63:0] hi);
        logic fixed;
        fixed = (b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
                (b inside {8'h5F, 8'h2D, 8'h2E, 8'h21, 8'h7E, 8'h27, 8'h28, 8'h29, 8'h2A});
        if (fixed) begin
            return 1'b1;
        end else if (b[7]) begin
            return 1'b0;
        end else if (b[6]) begin
            return hi[b[5:0]];
        end else begin
            return lo[b[5:0]];
        end
    endfunction

    function automatic logic is_hex(logic [7:0] b);
        return b inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
    endfunction

    // Only meaningful for a byte that is_hex accepts.
    function automatic logic [3:0] hex_value(logic [7:0] b);
        if (b inside {[8'h30:8'h39]}) begin
            return b[3:0];
        end else begin
            return b[3:0] + 4'd9;
        end
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + {4'd0, v};
        end else begin
            return 8'h37 + {4'd0, v};
        end
    endfunction

endpackage

[src/pcodec_front.sv]
// Front end: accepts input words, tracks the held decode bytes, builds output groups.
module pcodec_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pcodec_pkg::t_cfg      i_cfg,
    input  logic                  i_clr,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    input  logic                  i_space,
    output logic                  o_push,
    output pcodec_pkg::t_group    o_grp
);
    import pcodec_pkg::*;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_PCT   = 2'd1;
    localparam logic [1:0] PEND_DIGIT = 2'd2;

    logic [1:0] r_pcnt, n_pcnt;
    logic [7:0] r_pdig, n_pdig;
    t_group     grp;
    logic       accept;

    always_comb begin
        logic       use_fresh;
        logic [1:0] pn;
        n_pcnt    = r_pcnt;
        n_pdig    = r_pdig;
        grp       = '0;
        use_fresh = 1'b0;
        pn        = 2'd0;
        if (i_cfg.mode == MODE_ENCODE) begin
            n_pcnt = PEND_NONE;
            n_pdig = 8'd0;
            if (is_literal(i_byte, i_cfg.extra_lo, i_cfg.extra_hi)) begin
                grp.bytes[0] = i_byte;
                grp.cnt      = 2'd1;
            end else begin
                grp.bytes[0] = CH_PCT;
                grp.bytes[1] = hex_char(i_byte[7:4]);
                grp.bytes[2] = hex_char(i_byte[3:0]);
                grp.cnt      = 2'd3;
            end
        end else begin
            case (r_pcnt)
                PEND_PCT: begin
                    if (is_hex(i_byte) && !i_last) begin
                        n_pcnt = PEND_DIGIT;
                        n_pdig = i_byte;
                    end else begin
                        grp.bytes[0] = CH_PCT;
                        pn           = 2'd1;
                        use_fresh    = 1'b1;
                    end
                end
                PEND_DIGIT: begin
                    n_pdig = 8'd0;
                    if (is_hex(i_byte)) begin
                        grp.bytes[0] = {hex_value(r_pdig), hex_value(i_byte)};
                        grp.cnt      = 2'd1;
                        n_pcnt       = PEND_NONE;
                    end else begin
                        grp.bytes[0] = CH_PCT;
                        grp.bytes[1] = r_pdig;
                        pn           = 2'd2;
                        use_fresh    = 1'b1;
                    end
                end
                default: begin
                    use_fresh = 1'b1;
                end
            endcase
            if (use_fresh) begin
                if (i_byte == CH_PCT && !i_last) begin
                    n_pcnt  = PEND_PCT;
                    grp.cnt = pn;
                end else begin
                    n_pcnt        = PEND_NONE;
                    grp.bytes[pn] = i_byte;
                    grp.cnt       = pn + 2'd1;
                end
            end
        end
        if (i_last) begin
            n_pcnt = PEND_NONE;
            n_pdig = 8'd0;
        end
        grp.last = i_last;
    end

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;
    assign o_push  = accept && (grp.cnt != 2'd0);
    assign o_grp   = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_pcnt <= PEND_NONE;
            r_pdig <= 8'd0;
        end else if (accept) begin
            r_pcnt <= n_pcnt;
            r_pdig <= n_pdig;
        end
    end

endmodule

[src/pcodec_queue.sv]
// Short queue of output groups between the front end and the back end.
module pcodec_queue #(
    parameter int unsigned DEPTH = pcodec_pkg::Q_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  pcodec_pkg::t_group     i_grp,
    input  logic                   i_pop,
    output pcodec_pkg::t_group     o_head,
    output pcodec_pkg::t_q_status  o_stat
);
    import pcodec_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_group        r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[src/pcodec_back.sv]
// Back end: sends group bytes through an output register, one word per cycle while i_ready is high.
module pcodec_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pcodec_pkg::t_group     i_head,
    input  pcodec_pkg::t_q_status  i_stat,
    output logic                   o_pop,
    output logic                   o_busy,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_byte,
    output logic                   o_last
);
    import pcodec_pkg::*;

    t_group     r_cur;
    logic       r_cur_valid;
    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       load_out, cur_take, cur_done;

    assign load_out = !r_out_valid || i_ready;
    assign cur_take = load_out && r_cur_valid;
    assign cur_done = cur_take && (r_idx == r_cur.cnt - 2'd1);
    assign o_pop    = !i_stat.empty && (!r_cur_valid || cur_done);
    assign o_busy   = r_cur_valid;
    assign o_valid  = r_out_valid;
    assign o_byte   = r_out_byte;
    assign o_last   = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cur_valid <= 1'b1;
                r_idx       <= 2'd0;
            end else if (cur_done) begin
                r_cur_valid <= 1'b0;
            end else if (cur_take) begin
                r_idx <= r_idx + 2'd1;
            end
            if (load_out) begin
                r_out_valid <= r_cur_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
        if (cur_take) begin
            r_out_byte <= r_cur.bytes[r_idx];
            r_out_last <= r_cur.last && (r_idx == r_cur.cnt - 2'd1);
        end
    end

endmodule

[src/percent_uri_codec_core.sv]
// Top level of the streaming URI percent encoder and decoder.
//
//  Channel  | Valid / ready            | Payload
//  ---------+--------------------------+------------------------------------
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//  input    | i_valid / o_ready        | i_in_byte, i_in_last
//  output   | o_valid / i_ready        | o_out_byte, o_out_last
//
// Each input word is classified by the front end in the cycle it is accepted,
// so the input side can take one word per cycle while the queue has room.
// The back end delivers one output word per cycle while i_ready is high. An
// input byte yields none while it is held in an escape, one for a literal or
// decoded byte, one to three when a broken escape is flushed, three if encoded.
// Reset (synchronous, active low) clears the registers, held bytes, queue and
// output register. A stalled output fills the queue and then drops o_ready.
module percent_uri_codec_core #(
    parameter int unsigned QUEUE_DEPTH = pcodec_pkg::Q_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pcodec_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcodec_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [7:0]                        i_in_byte,
    input  logic                              i_in_last,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [7:0]                        o_out_byte,
    output logic                              o_out_last
);
    import pcodec_pkg::*;

    `include "percent_uri_codec_core_macros.svh"

    // Configuration registers. Writes are always taken; an index past the
    // last register is simply ignored.
    t_cfg      r_cfg;
    logic      cfg_wr;
    logic      mode_wr;
    logic      push, pop, back_busy;
    t_group    grp, head;
    t_q_status q_stat;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign mode_wr     = cfg_wr && (i_cfg_index == REG_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_MODE:     r_cfg.mode     <= i_cfg_data[0];
                REG_EXTRA_LO: r_cfg.extra_lo <= i_cfg_data;
                REG_EXTRA_HI: r_cfg.extra_hi <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front end works out the whole group for a byte at once and drops
    // any partial escape when the mode register is written.
    pcodec_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_clr   (mode_wr),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_byte  (i_in_byte),
        .i_last  (i_in_last),
        .i_space (!q_stat.full),
        .o_push  (push),
        .o_grp   (grp)
    );

    // Groups wait here so that the input side keeps running while the
    // back end spells out a three-byte escape.
    pcodec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_grp   (grp),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // The back end walks each group byte by byte; the last flag only goes
    // on the final byte of a group that came from a last input byte.
    pcodec_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_stat  (q_stat),
        .o_pop   (pop),
        .o_busy  (back_busy),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_byte  (o_out_byte),
        .o_last  (o_out_last)
    );

    // Every byte accepted in encode mode produces at least one output word.
    `PCODEC_ASSERT(a_encode_pushes, (i_valid && o_ready && r_cfg.mode == MODE_ENCODE) |-> push)
    // Nothing can appear at the output without a group queued or in progress.
    `PCODEC_ASSERT(a_no_spurious_out, (!o_valid && q_stat.empty && !back_busy) |=> !o_valid)
    // The output register is empty in the cycle after a reset cycle.
    `PCODEC_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_valid)

endmodule
